### src/ebml_id_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// ebml id stream decoder assertion macros
// concurrent assertion shorthands clocked on aclk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef EBML_ID_STREAM_DECODER_ASSERT_SVH
`define EBML_ID_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define EBMLID_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ebml id decoder: same-cycle check failed");

// next-cycle implication
`define EBMLID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ebml id decoder: next-cycle check failed");

`endif

### src/ebmlid_pkg.sv
// ----------------------------------------------------------------------------
// ebmlid_pkg
// shared types and constants of the ebml element id stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package ebmlid_pkg;

    localparam int unsigned ID_W     = 29;
    localparam int unsigned LEN_W    = 4;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TDATA_W  = 40;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_VARINT = 2'd1,
        STATUS_BAD_ID     = 2'd2
    } status_t;

    // all-ones value of each valid id length, which is reserved
    localparam logic [ID_W-1:0] ID_ONES_1 = 29'h0000_00FF;
    localparam logic [ID_W-1:0] ID_ONES_2 = 29'h0000_7FFF;
    localparam logic [ID_W-1:0] ID_ONES_3 = 29'h003F_FFFF;
    localparam logic [ID_W-1:0] ID_ONES_4 = 29'h1FFF_FFFF;

    // one result word
    typedef struct packed {
        logic [ID_W-1:0]  element_id;
        logic [LEN_W-1:0] id_length;
        status_t          status;
    } result_t;

endpackage

`default_nettype wire

### src/ebmlid_check.sv
// ----------------------------------------------------------------------------
// ebmlid_check
// validates a completed id against its declared length and forms the result
// ----------------------------------------------------------------------------
`default_nettype none

module ebmlid_check (
    input  wire logic [ebmlid_pkg::ID_W-1:0]  id_value,
    input  wire logic [ebmlid_pkg::LEN_W-1:0] id_length,
    output ebmlid_pkg::result_t               result
);

    logic id_ok;

    // lengths one to four are valid unless the value is all ones
    always_comb begin
        unique case (id_length)
            4'd1:    id_ok = (id_value != ebmlid_pkg::ID_ONES_1);
            4'd2:    id_ok = (id_value != ebmlid_pkg::ID_ONES_2);
            4'd3:    id_ok = (id_value != ebmlid_pkg::ID_ONES_3);
            4'd4:    id_ok = (id_value != ebmlid_pkg::ID_ONES_4);
            default: id_ok = 1'b0;
        endcase
    end

    // invalid ids report a zero value
    always_comb begin
        result.element_id = id_ok ? id_value : '0;
        result.id_length  = id_length;
        result.status     = id_ok ? ebmlid_pkg::STATUS_OK : ebmlid_pkg::STATUS_BAD_ID;
    end

endmodule

`default_nettype wire

### src/ebml_id_stream_decoder.sv
// ----------------------------------------------------------------------------
// ebml_id_stream_decoder
// byte stream parser for ebml element ids with one result word per id
// ----------------------------------------------------------------------------
// One byte word is accepted every cycle while the result side keeps up. Each
// byte passes an input register, then the decode logic updates the byte
// count and accumulator and loads the result register as the last byte of an
// id leaves the input register. A stalled result holds in the output register
// while one more byte still enters the input register; the input side stalls
// only when both registers are full. A zero leading byte gives an invalid
// varint result at once; ids of five to eight bytes are consumed whole and
// reported as invalid ids.
// ----------------------------------------------------------------------------
`default_nettype none

module ebml_id_stream_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_axis_tdata: data_byte[7:0]
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    // m_axis_tdata: element_id[28:0], id_length[32:29], status[34:33], zero[39:35]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata
);

    localparam int unsigned ID_W  = ebmlid_pkg::ID_W;
    localparam int unsigned LEN_W = ebmlid_pkg::LEN_W;

    // leading byte length from its highest set bit, zero when none
    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] len;
        if (b[7]) begin
            len = 4'd1;
        end else if (b[6]) begin
            len = 4'd2;
        end else if (b[5]) begin
            len = 4'd3;
        end else if (b[4]) begin
            len = 4'd4;
        end else if (b[3]) begin
            len = 4'd5;
        end else if (b[2]) begin
            len = 4'd6;
        end else if (b[1]) begin
            len = 4'd7;
        end else if (b[0]) begin
            len = 4'd8;
        end else begin
            len = 4'd0;
        end
        return len;
    endfunction

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   advance;

    logic [2:0]             remaining_reg, remaining_next;
    logic [ID_W-1:0]        acc_reg, acc_next;
    logic [LEN_W-1:0]       total_reg, total_next;
    logic [LEN_W-1:0]       lead_len;
    logic                   finish;
    logic                   bad_varint;

    ebmlid_pkg::result_t    chk_result;
    ebmlid_pkg::result_t    result_reg;
    logic                   out_valid_reg;

    // pipeline moves when the result register is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // decode step: leading byte or continuation byte
    always_comb begin
        lead_len       = lead_length(in_byte_reg);
        remaining_next = remaining_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        finish         = 1'b0;
        bad_varint     = 1'b0;
        if (remaining_reg == 3'd0) begin
            if (lead_len == 4'd0) begin
                acc_next   = '0;
                total_next = '0;
                bad_varint = 1'b1;
            end else begin
                acc_next   = {{(ID_W-8){1'b0}}, in_byte_reg};
                total_next = lead_len;
                if (lead_len == 4'd1) begin
                    finish = 1'b1;
                end else begin
                    remaining_next = 3'(lead_len - 4'd1);
                end
            end
        end else begin
            acc_next       = {acc_reg[ID_W-9:0], in_byte_reg};
            remaining_next = remaining_reg - 3'd1;
            finish         = (remaining_reg == 3'd1);
        end
    end

    ebmlid_check u_check (
        .id_value  (acc_next),
        .id_length (total_next),
        .result    (chk_result)
    );

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
            acc_reg       <= '0;
            total_reg     <= '0;
        end else if (advance) begin
            remaining_reg <= remaining_next;
            acc_reg       <= acc_next;
            total_reg     <= total_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && (finish || bad_varint)) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && (finish || bad_varint)) begin
            if (bad_varint) begin
                result_reg.element_id <= '0;
                result_reg.id_length  <= 4'd1;
                result_reg.status     <= ebmlid_pkg::STATUS_BAD_VARINT;
            end else begin
                result_reg <= chk_result;
            end
        end
    end

    // output word packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, result_reg.status, result_reg.id_length,
                            result_reg.element_id};

endmodule

`default_nettype wire

### src/ebmlid_sva.sv
// ----------------------------------------------------------------------------
// ebmlid_sva
// port-level checks of the ebml id stream decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "ebml_id_stream_decoder_assert.svh"

module ebmlid_sva (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    logic [1:0]  status;
    logic [3:0]  id_length;
    logic [28:0] element_id;
    logic        unused_in;
    logic        stalled;
    logic        err_word;
    logic        varint_word;
    logic        ok_word;

    assign status      = m_axis_tdata[34:33];
    assign id_length   = m_axis_tdata[32:29];
    assign element_id  = m_axis_tdata[28:0];
    assign unused_in   = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata);
    assign stalled     = m_axis_tvalid && !m_axis_tready;
    assign err_word    = m_axis_tvalid && (status != ebmlid_pkg::STATUS_OK);
    assign varint_word = m_axis_tvalid && (status == ebmlid_pkg::STATUS_BAD_VARINT);
    assign ok_word     = m_axis_tvalid && (status == ebmlid_pkg::STATUS_OK);

    // a stalled result word holds
    `EBMLID_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata))

    // failed ids carry a zero value
    `EBMLID_ASSERT_NOW(a_err_zero_id, err_word, element_id == 29'd0)

    // a zero leading byte occupies exactly one byte
    `EBMLID_ASSERT_NOW(a_varint_len, varint_word, id_length == 4'd1)

    // valid ids are one to four bytes long
    `EBMLID_ASSERT_NOW(a_ok_len, ok_word, (id_length >= 4'd1) && (id_length <= 4'd4))

endmodule

bind ebml_id_stream_decoder ebmlid_sva u_ebmlid_sva (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### dv/tb_ebml_id_stream_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ebml_id_stream_decoder
// self-checking bench for the ebml element id byte stream decoder
// ----------------------------------------------------------------------------
// Byte words are fed through the input stream in bursts with random gaps,
// while the result stream stalls on a rotating ready pattern and once holds
// off for a long stretch. Every accepted byte goes through a bench-side id
// decoder, and each result word is compared field by field with the oldest
// predicted id. A short directed run covers the zero leading byte, the
// reserved all-ones ids and the over-long ids. After it comes a mostly
// well-formed random id stream, mixed with loose noise bytes.
// ----------------------------------------------------------------------------

module tb_ebml_id_stream_decoder;

    localparam int unsigned N_BYTES     = 950;
    localparam int unsigned HOLD_AT     = 400;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned MAX_REPORTS = 10;

    // one pending byte word, optionally held back until all ids are out
    typedef struct {
        logic [ebmlid_pkg::BYTE_W-1:0] data_byte;
        bit                            drain_first;
    } byte_word_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'h00;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [39:0]        m_axis_tdata;

    byte_word_t          byte_q[$];
    ebmlid_pkg::result_t expected_ids[$];

    // bench copy of the decoder state
    logic [2:0]         bytes_left = '0;
    logic [31:0]        id_acc = '0;
    logic [3:0]         id_len = '0;

    int unsigned        bytes_taken = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        burst_left = 0;
    int unsigned        gap_left = 0;
    logic [15:0]        ready_pat = 16'hFFFF;
    int unsigned        pat_age = 0;
    logic               hold_off = 1'b0;
    int unsigned        hold_cycles = 0;
    logic               hold_done = 1'b0;

    ebml_id_stream_decoder i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // result of a completed id: valid only for 1 to 4 bytes, not all ones
    function automatic ebmlid_pkg::result_t close_id(input logic [31:0] acc,
                                                     input logic [3:0]  len);
        ebmlid_pkg::result_t r;
        logic [63:0]         lo;
        logic [63:0]         hi;
        lo = 64'd1 << (7 * len);
        hi = (64'd2 << (7 * len)) - 64'd2;
        r.id_length = len;
        if (len >= 4'd1 && len <= 4'd4 && {32'd0, acc} >= lo && {32'd0, acc} <= hi) begin
            r.element_id = acc[ebmlid_pkg::ID_W-1:0];
            r.status     = ebmlid_pkg::STATUS_OK;
        end else begin
            r.element_id = '0;
            r.status     = ebmlid_pkg::STATUS_BAD_ID;
        end
        return r;
    endfunction

    // advance the bench decoder by one byte, queueing any finished id
    task automatic decode_id_byte(input logic [7:0] b);
        int unsigned         lead_len;
        ebmlid_pkg::result_t r;
        lead_len = 0;
        if (bytes_left == 3'd0) begin
            // highest set bit wins, so walk upwards and keep the last hit
            for (int i = 0; i < 8; i++) begin
                if (b[i]) lead_len = 8 - i;
            end
            if (lead_len == 0) begin
                id_acc = '0;
                id_len = '0;
                r.element_id = '0;
                r.id_length  = 4'd1;
                r.status     = ebmlid_pkg::STATUS_BAD_VARINT;
                expected_ids.push_back(r);
            end else begin
                id_acc = {24'd0, b};
                id_len = 4'(lead_len);
                if (lead_len == 1) expected_ids.push_back(close_id(id_acc, id_len));
                else bytes_left = 3'(lead_len - 1);
            end
        end else begin
            id_acc = {id_acc[23:0], b};
            bytes_left = bytes_left - 3'd1;
            if (bytes_left == 3'd0) expected_ids.push_back(close_id(id_acc, id_len));
        end
    endtask

    // queue one byte word; drain pauses sit at fixed points of the stream
    task automatic add_byte(input logic [7:0] b);
        byte_word_t w;
        w.data_byte   = b;
        w.drain_first = (byte_q.size() == 25) || (byte_q.size() == 600);
        byte_q.push_back(w);
    endtask

    // driver: bursts of words separated by random gaps
    always @(posedge aclk) begin : driver
        logic       v_next;
        logic [7:0] d_next;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
        end else begin
            v_next = s_axis_tvalid;
            d_next = s_axis_tdata;
            if (s_axis_tvalid && s_axis_tready) begin
                decode_id_byte(s_axis_tdata);
                bytes_taken++;
                v_next = 1'b0;
            end
            if (!v_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_q.size() > 0 &&
                             !(byte_q[0].drain_first && expected_ids.size() != 0)) begin
                    d_next = byte_q[0].data_byte;
                    v_next = 1'b1;
                    void'(byte_q.pop_front());
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
            end
            s_axis_tvalid <= v_next;
            s_axis_tdata  <= d_next;
        end
    end

    // one long hold-off of the result side once the stream is well under way
    always @(posedge aclk) begin : long_hold
        if (!aresetn) begin
            hold_off    <= 1'b0;
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end else if (hold_off) begin
            if (hold_cycles == 0) hold_off <= 1'b0;
            else hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && bytes_taken >= HOLD_AT) begin
            hold_off    <= 1'b1;
            hold_cycles <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end
    end

    // monitor: checks result words and drives the ready stall pattern
    always @(posedge aclk) begin : monitor
        ebmlid_pkg::result_t want;
        ebmlid_pkg::result_t got;
        logic [4:0]          pad;
        int unsigned         mode;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.element_id = m_axis_tdata[28:0];
                got.id_length  = m_axis_tdata[32:29];
                got.status     = ebmlid_pkg::status_t'(m_axis_tdata[34:33]);
                pad            = m_axis_tdata[39:35];
                if (expected_ids.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected id word: id %h len %0d status %0d",
                                 got.element_id, got.id_length, got.status);
                end else begin
                    want = expected_ids.pop_front();
                    if (got.element_id != want.element_id || got.id_length != want.id_length ||
                        got.status != want.status || pad != 5'd0) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("id mismatch: want %h/%0d/%0d got %h/%0d/%0d pad %h",
                                     want.element_id, want.id_length, want.status,
                                     got.element_id, got.id_length, got.status, pad);
                    end
                end
            end
            // stall pattern rotates and is replaced when pat_age wraps: none, random or light
            pat_age++;
            if (pat_age >= 64) begin
                pat_age = 0;
                mode = $urandom_range(0, 2);
                if (mode == 0) ready_pat = 16'hFFFF;
                else if (mode == 1) ready_pat = 16'($urandom);
                else ready_pat = 16'($urandom) | 16'($urandom);
            end else begin
                ready_pat = {ready_pat[0], ready_pat[15:1]};
            end
            m_axis_tready <= !hold_off && ready_pat[0];
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int unsigned kind;
        int unsigned flavour;
        int unsigned idlen;
        logic [7:0]  marker;
        logic [7:0]  lead;
        logic [7:0]  tail;

        // zero leading byte, shortest ids at both ends and all-ones ids
        add_byte(8'h00);
        add_byte(8'h80);
        add_byte(8'hFF);
        add_byte(8'h7F); add_byte(8'hFE);
        add_byte(8'h3F); add_byte(8'hFF); add_byte(8'hFF);
        add_byte(8'h1F); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF);
        // five-byte and eight-byte ids, consumed whole
        add_byte(8'h08);
        repeat (4) add_byte(8'hFF);
        add_byte(8'h01);
        repeat (7) add_byte(8'h00);

        // random id stream with some loose noise bytes
        while (byte_q.size() < N_BYTES) begin
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
                add_byte(8'($urandom));
            end else if (kind < 16) begin
                add_byte(8'h00);
            end else begin
                idlen   = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4)
                                                      : $urandom_range(5, 8);
                marker  = 8'h80 >> (idlen - 1);
                flavour = $urandom_range(0, 9);
                if (flavour == 0) begin
                    lead = marker | (marker - 8'd1);
                    tail = 8'hFF;
                end else if (flavour == 1) begin
                    lead = marker;
                    tail = 8'h00;
                end else begin
                    lead = marker | (8'($urandom) & (marker - 8'd1));
                end
                add_byte(lead);
                for (int i = 1; i < idlen; i++) begin
                    add_byte((flavour < 2) ? tail : 8'($urandom));
                end
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_q.size() != 0 || s_axis_tvalid || expected_ids.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatch_count == 0 && expected_ids.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### ebml_id_stream_decoder.f
+incdir+src
src/ebmlid_pkg.sv
src/ebmlid_check.sv
src/ebml_id_stream_decoder.sv
src/ebmlid_sva.sv
dv/tb_ebml_id_stream_decoder.sv
